[hw/rtl/pls_pkg.sv]
package pls_pkg;

    localparam int LIST_DEPTH  = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int POS_W       = 7;
    localparam int CMD_W       = 3;
    localparam int ST_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_DELETE   = 3'd2,
        CMD_RETRIEVE = 3'd3,
        CMD_REPLACE  = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [ENTRY_WIDTH-1:0] wdata;
        logic                   re;
        logic [IDX_W-1:0]       raddr;
    } t_mem_req;

    typedef struct packed {
        logic                   valid;
        logic [ENTRY_WIDTH-1:0] value;
        t_status                status;
        logic [CNT_W-1:0]       count;
    } t_result;

endpackage

[hw/rtl/pls_store.sv]
module pls_store
    import pls_pkg::*;
(
    input  logic                   i_clk,
    input  t_mem_req               i_req,
    output logic [ENTRY_WIDTH-1:0] o_rdata
);

    logic [ENTRY_WIDTH-1:0] r_mem [LIST_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pls_ctrl.sv]
module pls_ctrl
    import pls_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [POS_W-1:0]       i_position,
    input  logic [ENTRY_WIDTH-1:0] i_new_value,
    output t_mem_req               o_req,
    input  logic [ENTRY_WIDTH-1:0] i_rdata,
    output t_result                o_res,
    input  logic                   i_res_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_PUT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_last, n_last;
    logic [IDX_W-1:0]       r_wa, n_wa;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [ENTRY_WIDTH-1:0] r_val, n_val;
    logic [ENTRY_WIDTH-1:0] r_value, n_value;
    t_status                r_status, n_status;
    logic                   r_up, n_up;
    logic                   r_ins, n_ins;
    logic                   r_more, n_more;
    logic                   r_first_cap, n_first_cap;
    logic                   r_rd_act, n_rd_act;
    logic                   r_rd_cap, n_rd_cap;

    logic [CNT_W-1:0]       w_cnt_m1;
    logic [IDX_W-1:0]       w_pos_idx;
    logic                   w_full;

    assign w_cnt_m1   = r_count - 1'b1;
    assign w_pos_idx  = i_position[IDX_W-1:0];
    assign w_full     = (r_count == CNT_W'(LIST_DEPTH));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_last      = r_last;
        n_wa        = r_wa;
        n_pos       = r_pos;
        n_val       = r_val;
        n_value     = r_value;
        n_status    = r_status;
        n_up        = r_up;
        n_ins       = r_ins;
        n_more      = r_more;
        n_first_cap = r_first_cap;
        n_rd_act    = r_rd_act;
        n_rd_cap    = r_rd_cap;
        o_req       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state     = S_DONE;
                    n_value     = '0;
                    n_status    = ST_OK;
                    n_rd_act    = 1'b0;
                    n_ins       = 1'b0;
                    n_pos       = w_pos_idx;
                    n_val       = i_new_value;
                    case (t_cmd'(i_command))
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_count[IDX_W-1:0];
                                o_req.wdata = i_new_value;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (i_position > r_count) begin
                                n_status = ST_BAD_POS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_ins   = 1'b1;
                                if (i_position == r_count) begin
                                    n_state = S_PUT;
                                end else begin
                                    // Walk downwards, moving each entry one place up.
                                    n_state     = S_MOVE;
                                    n_idx       = w_cnt_m1[IDX_W-1:0];
                                    n_last      = w_pos_idx;
                                    n_up        = 1'b0;
                                    n_more      = 1'b1;
                                    n_first_cap = 1'b0;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (i_position >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                // The first read returns the removed entry; the rest move down.
                                n_count     = w_cnt_m1;
                                n_state     = S_MOVE;
                                n_idx       = w_pos_idx;
                                n_last      = w_cnt_m1[IDX_W-1:0];
                                n_up        = 1'b1;
                                n_more      = 1'b1;
                                n_first_cap = 1'b1;
                            end
                        end
                        CMD_RETRIEVE: begin
                            if (i_position >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_state     = S_MOVE;
                                n_idx       = w_pos_idx;
                                n_last      = w_pos_idx;
                                n_up        = 1'b1;
                                n_more      = 1'b1;
                                n_first_cap = 1'b1;
                            end
                        end
                        CMD_REPLACE: begin
                            if (i_position >= r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = w_pos_idx;
                                o_req.wdata = i_new_value;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                // Data read in the previous cycle is either captured or written back.
                if (r_rd_act) begin
                    if (r_rd_cap) begin
                        n_value = i_rdata;
                    end else begin
                        o_req.we    = 1'b1;
                        o_req.waddr = r_wa;
                        o_req.wdata = i_rdata;
                    end
                end
                if (r_more) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_idx;
                    n_rd_act    = 1'b1;
                    n_rd_cap    = r_first_cap;
                    n_wa        = r_up ? (r_idx - 1'b1) : (r_idx + 1'b1);
                    n_first_cap = 1'b0;
                    if (r_idx == r_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_up ? (r_idx + 1'b1) : (r_idx - 1'b1);
                    end
                end else begin
                    n_rd_act = 1'b0;
                    if (!r_rd_act) begin
                        n_state = r_ins ? S_PUT : S_DONE;
                    end
                end
            end
            S_PUT: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_pos;
                o_req.wdata = r_val;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.valid  = (r_state == S_DONE);
        o_res.value  = r_value;
        o_res.status = r_status;
        o_res.count  = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_more   <= 1'b0;
            r_rd_act <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_more   <= n_more;
            r_rd_act <= n_rd_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_wa        <= n_wa;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_value     <= n_value;
        r_status    <= n_status;
        r_up        <= n_up;
        r_ins       <= n_ins;
        r_first_cap <= n_first_cap;
        r_rd_cap    <= n_rd_cap;
    end

endmodule

[hw/rtl/positional_list_store.sv]
// Ordered list of up to LIST_DEPTH entries kept contiguously in one memory.
// Input channel (i_in_valid / o_in_ready) carries one command beat: append,
// insert, delete, retrieve, replace or clear, with a position and a value.
// Output channel (o_out_valid / i_out_ready) returns exactly one result beat
// per command: the value read, a status, the new count and empty/full flags.
// Commands are handled one at a time. Append, replace, clear, failed commands
// and unused codes go straight to the result; insert at the end of the list
// first writes the value, and retrieve reads the entry through the memory.
// Insert and delete move entries through the memory's one read port and one
// write port, one entry per cycle, pipelined over the registered read. The
// next command is accepted once the result has been placed in the output
// register. Reset empties the list; memory contents are not cleared, as
// entries above the count are never read. If the receiver stalls, the result
// is held in the output register, the controller keeps the following result
// until that register is free, and o_in_ready stays low meanwhile.
module positional_list_store
    import pls_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [POS_W-1:0]       i_position,
    input  logic [ENTRY_WIDTH-1:0] i_new_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [ENTRY_WIDTH-1:0] o_read_value,
    output logic [ST_W-1:0]        o_status,
    output logic [CNT_W-1:0]       o_count_now,
    output logic                   o_is_empty,
    output logic                   o_is_full
);

    t_mem_req               w_req;
    t_result                w_res;
    logic [ENTRY_WIDTH-1:0] w_rdata;
    logic                   w_res_ready;

    logic                   r_out_valid;
    logic [ENTRY_WIDTH-1:0] r_read_value;
    logic [ST_W-1:0]        r_status;
    logic [CNT_W-1:0]       r_count_now;
    logic                   r_is_empty;
    logic                   r_is_full;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .o_req       (w_req),
        .i_rdata     (w_rdata),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    pls_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res.valid) begin
            r_read_value <= w_res.value;
            r_status     <= w_res.status;
            r_count_now  <= w_res.count;
            r_is_empty   <= (w_res.count == '0);
            r_is_full    <= (w_res.count == CNT_W'(LIST_DEPTH));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count_now  = r_count_now;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while one is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count_now <= CNT_W'(LIST_DEPTH))
        else $error("count beyond list depth");

    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_read_value == '0)
        else $error("failed command returned data");

    a_port_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.we && w_req.re |-> w_req.waddr != w_req.raddr)
        else $error("read and write to the same entry in one cycle");
`endif

endmodule
